/* rtl/core/ybs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_pkg
// Shared types and codes for the YMODEM block sender.
// ----------------------------------------------------------------------------
package ybs_pkg;

  localparam logic [2:0] CMD_BEGIN = 3'd0;
  localparam logic [2:0] CMD_DATA  = 3'd1;
  localparam logic [2:0] CMD_PAD   = 3'd2;
  localparam logic [2:0] CMD_EOT   = 3'd3;
  localparam logic [2:0] CMD_REPLY = 3'd4;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_LAST   = 2'd2;
  localparam logic [1:0] KIND_ZERO   = 2'd3;

  localparam logic [2:0] EXP_NONE   = 3'd0;
  localparam logic [2:0] EXP_HEADER = 3'd1;
  localparam logic [2:0] EXP_DATA   = 3'd2;
  localparam logic [2:0] EXP_LAST   = 3'd3;
  localparam logic [2:0] EXP_ZERO   = 3'd4;
  localparam logic [2:0] EXP_EOT1   = 3'd5;
  localparam logic [2:0] EXP_EOT2   = 3'd6;

  localparam logic [2:0] ST_SENT       = 3'd0;
  localparam logic [2:0] ST_REPLY_PART = 3'd1;
  localparam logic [2:0] ST_REPLY_OK   = 3'd2;
  localparam logic [2:0] ST_REPLY_ERR  = 3'd3;
  localparam logic [2:0] ST_CMD_ERR    = 3'd4;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [1:0] CFG_DATA_FILL   = 2'd0;
  localparam logic [1:0] CFG_DATA_SECOND = 2'd1;
  localparam logic [1:0] CFG_HDR_SECOND  = 2'd2;

  localparam logic [7:0] RST_DATA_FILL   = 8'h1A;
  localparam logic [7:0] RST_DATA_SECOND = 8'h78;
  localparam logic [7:0] RST_HDR_SECOND  = 8'h43;

  // One queued job: up to three results that share tx_valid and status.
  typedef struct packed {
    logic [1:0] cnt;
    logic       tx_valid;
    logic [2:0] status;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } job_t;

endpackage

/* rtl/core/ybs_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_in_if
// Command channel: valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
interface ybs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_value;
  logic [1:0] block_kind;
  logic [7:0] block_number;

  modport source (output valid, command, data_value, block_kind, block_number,
                  input ready);
  modport sink   (input valid, command, data_value, block_kind, block_number,
                  output ready);
endinterface

/* rtl/core/ybs_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_out_if
// Result channel: valid/ready handshake with one result per transfer.
// ----------------------------------------------------------------------------
interface ybs_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       run_last;
  logic [2:0] status;

  modport source (output valid, tx_valid, tx_byte, run_last, status, input ready);
  modport sink   (input valid, tx_valid, tx_byte, run_last, status, output ready);
endinterface

/* rtl/core/ybs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_front
// Accepts commands, checks them against the link state, updates the CRC and
// block state, and pushes one job of up to three results into the queue.
// ----------------------------------------------------------------------------
module ybs_front import ybs_pkg::*; #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  ybs_in_if.sink       in_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_wdata,
  input  logic         q_full,
  output logic         push,
  output job_t         push_job
);

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

  logic [7:0]       fill_r, dsec_r, hsec_r;
  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             open_r, open_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic             pad_r, pad_nxt;
  logic [2:0]       exp_r, exp_nxt;
  logic             pos_r, pos_nxt;
  logic             eot_r, eot_nxt;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'd0) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    logic [7:0]       pay;
    logic             do_pay;
    logic             ok;
    logic             two;
    logic [7:0]       num;
    logic [15:0]      crc_new;
    logic [CNT_W-1:0] cnt_inc;

    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    open_nxt = open_r;
    kind_nxt = kind_r;
    pad_nxt  = pad_r;
    exp_nxt  = exp_r;
    pos_nxt  = pos_r;
    eot_nxt  = eot_r;
    pay      = 8'd0;
    do_pay   = 1'b0;
    ok       = 1'b0;
    two      = 1'b0;
    num      = 8'd0;
    crc_new  = 16'd0;
    cnt_inc  = '0;

    push_job = '{cnt: 2'd1, tx_valid: 1'b0, status: ST_CMD_ERR,
                 byte0: 8'd0, byte1: 8'd0, byte2: 8'd0};

    if (in_ch.command == CMD_REPLY) begin
      if (exp_r != EXP_NONE) begin
        two = exp_r inside {EXP_HEADER, EXP_DATA, EXP_LAST};
        if (!pos_r) ok = (in_ch.data_value == ((exp_r == EXP_EOT1) ? BYTE_NAK : BYTE_ACK));
        else if (exp_r == EXP_HEADER) ok = (in_ch.data_value == hsec_r);
        else if (exp_r == EXP_DATA) ok = (in_ch.data_value == dsec_r);
        else ok = 1'b1;

        if (!ok) begin
          exp_nxt = EXP_NONE;
          pos_nxt = 1'b0;
          eot_nxt = 1'b0;
          push_job.status = ST_REPLY_ERR;
        end else if (two && !pos_r) begin
          pos_nxt = 1'b1;
          push_job.status = ST_REPLY_PART;
        end else begin
          if (exp_r == EXP_EOT1) eot_nxt = 1'b1;
          else if (exp_r == EXP_EOT2) eot_nxt = 1'b0;
          exp_nxt = EXP_NONE;
          pos_nxt = 1'b0;
          push_job.status = ST_REPLY_OK;
        end
      end
    end else if (exp_r == EXP_NONE) begin
      case (in_ch.command)
        CMD_BEGIN: begin
          if (!open_r) begin
            num = (in_ch.block_kind == KIND_HEADER || in_ch.block_kind == KIND_ZERO) ?
                  8'd0 : in_ch.block_number;
            open_nxt = 1'b1;
            kind_nxt = in_ch.block_kind;
            pad_nxt  = 1'b0;
            cnt_nxt  = '0;
            crc_nxt  = 16'd0;
            eot_nxt  = 1'b0;
            push_job = '{cnt: 2'd3, tx_valid: 1'b1, status: ST_SENT,
                         byte0: BYTE_SOH, byte1: num, byte2: ~num};
          end
        end
        CMD_DATA: begin
          if (open_r && !pad_r && kind_r != KIND_ZERO) begin
            pay    = in_ch.data_value;
            do_pay = 1'b1;
          end
        end
        CMD_PAD: begin
          if (open_r) begin
            case (kind_r)
              KIND_HEADER: pay = pad_r ? 8'd0 : 8'(cnt_r);
              KIND_ZERO:   pay = 8'd0;
              default:     pay = fill_r;
            endcase
            pad_nxt = 1'b1;
            do_pay  = 1'b1;
          end
        end
        CMD_EOT: begin
          if (!open_r) begin
            exp_nxt  = eot_r ? EXP_EOT2 : EXP_EOT1;
            pos_nxt  = 1'b0;
            push_job = '{cnt: 2'd1, tx_valid: 1'b1, status: ST_SENT,
                         byte0: BYTE_EOT, byte1: 8'd0, byte2: 8'd0};
          end
        end
        default: ;
      endcase
    end

    if (do_pay) begin
      crc_new  = crc_step(crc_r, pay);
      cnt_inc  = cnt_r + CNT_W'(1);
      crc_nxt  = crc_new;
      cnt_nxt  = cnt_inc;
      push_job = '{cnt: 2'd1, tx_valid: 1'b1, status: ST_SENT,
                   byte0: pay, byte1: 8'd0, byte2: 8'd0};
      // last payload byte closes the block and appends the CRC
      if (cnt_inc >= CNT_W'(PAYLOAD_BYTES)) begin
        push_job.cnt   = 2'd3;
        push_job.byte1 = crc_new[15:8];
        push_job.byte2 = crc_new[7:0];
        open_nxt = 1'b0;
        pos_nxt  = 1'b0;
        case (kind_r)
          KIND_HEADER: exp_nxt = EXP_HEADER;
          KIND_DATA:   exp_nxt = EXP_DATA;
          KIND_LAST:   exp_nxt = EXP_LAST;
          default:     exp_nxt = EXP_ZERO;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= RST_DATA_FILL;
      dsec_r <= RST_DATA_SECOND;
      hsec_r <= RST_HDR_SECOND;
      crc_r  <= 16'd0;
      cnt_r  <= '0;
      open_r <= 1'b0;
      kind_r <= KIND_HEADER;
      pad_r  <= 1'b0;
      exp_r  <= EXP_NONE;
      pos_r  <= 1'b0;
      eot_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DATA_FILL:   fill_r <= cfg_wdata;
          CFG_DATA_SECOND: dsec_r <= cfg_wdata;
          CFG_HDR_SECOND:  hsec_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (push) begin
        crc_r  <= crc_nxt;
        cnt_r  <= cnt_nxt;
        open_r <= open_nxt;
        kind_r <= kind_nxt;
        pad_r  <= pad_nxt;
        exp_r  <= exp_nxt;
        pos_r  <= pos_nxt;
        eot_r  <= eot_nxt;
      end
    end
  end

endmodule

/* rtl/core/ybs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_queue
// Two-entry job queue between the command front and the result back.
// ----------------------------------------------------------------------------
module ybs_queue import ybs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  localparam int DEPTH = 2;

  job_t       mem_r [DEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full  = (count_r == 2'(DEPTH));
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/core/ybs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ybs_back
// Walks the head job one result per cycle while ready; pops it after the last.
// ----------------------------------------------------------------------------
module ybs_back import ybs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      empty,
  input  job_t      head,
  output logic      pop,
  ybs_out_if.source out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic       last;
  logic       fire;

  assign last = (idx_r == head.cnt - 2'd1);
  assign fire = out_ch.valid && out_ch.ready;
  assign pop  = fire && last;

  assign out_ch.valid    = !empty;
  assign out_ch.tx_valid = head.tx_valid;
  assign out_ch.run_last = last;
  assign out_ch.status   = head.status;

  always_comb begin
    case (idx_r)
      2'd0:    out_ch.tx_byte = head.byte0;
      2'd1:    out_ch.tx_byte = head.byte1;
      default: out_ch.tx_byte = head.byte2;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (fire) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

/* rtl/core/ymodem_block_sender_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ymodem_block_sender_top
// YMODEM-style block sender: frames blocks, runs CRC-16, checks replies.
// ----------------------------------------------------------------------------
// An accepted item's job is registered into the queue; its first result shows
// once earlier jobs have drained. Results leave one per cycle while ready is
//   high; an item yields one result, a framing item (begin, closing byte) 3.
// A two-entry job queue lets commands be taken while results drain.
// Reset (synchronous, rst_n low): link state cleared, queue emptied, registers
//   back to fill 0x1A, data reply 0x78, header reply 0x43.
module ymodem_block_sender_top import ybs_pkg::*; #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  ybs_in_if.sink     in_ch,
  ybs_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic q_full, q_empty, push, pop;
  job_t push_job, head;

  ybs_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk, .rst_n, .in_ch, .cfg_we, .cfg_index, .cfg_wdata,
    .q_full, .push, .push_job
  );

  ybs_queue u_queue (
    .clk, .rst_n, .push, .push_job, .pop,
    .full(q_full), .empty(q_empty), .head
  );

  ybs_back u_back (
    .clk, .rst_n, .empty(q_empty), .head, .pop, .out_ch
  );

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !q_empty) else $error("accepted item did not reach the queue");

  a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> head.cnt != 2'd0) else $error("queued job has no results");

  a_silent_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.tx_valid |-> out_ch.run_last && out_ch.tx_byte == 8'd0)
    else $error("status result not a single zero-byte item");

  a_sent_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.tx_valid |-> out_ch.status == ST_SENT)
    else $error("transmitted byte with non-sent status");

endmodule
